FILE: design/crp_pkg.sv
// Shared types, codes and helper functions for the classless route parser.
`default_nettype none
package crp_pkg;

  // Parser phase codes
  localparam logic [1:0] PH_PREFIX = 2'd0;
  localparam logic [1:0] PH_DEST   = 2'd1;
  localparam logic [1:0] PH_GW     = 2'd2;
  localparam logic [1:0] PH_STOP   = 2'd3;

  // Status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_PREFIX = 2'd1;
  localparam logic [1:0] ST_TRUNC  = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_IFACE_ADDR = 2'd0;
  localparam logic [1:0] CFG_IFACE_MASK = 2'd1;
  localparam logic [1:0] CFG_BCAST_EN   = 2'd2;

  localparam logic [5:0] MAX_PREFIX = 6'd32;
  localparam logic [5:0] COUNT_MAX  = 6'd63;
  localparam logic [2:0] GW_OCTETS  = 3'd4;

  typedef struct packed {
    logic [31:0] iface_addr;
    logic [31:0] iface_mask;
    logic        broadcast_enable;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic        route_valid;
    logic [31:0] dest_addr;
    logic [5:0]  prefix_length;
    logic [31:0] gateway_addr;
    logic        clear_routes;
    logic        option_done;
    logic [5:0]  route_count;
    logic [1:0]  status;
  } result_t;

  // Destination octets carried for a prefix length of 0 to 32
  function automatic logic [2:0] octets_for(input logic [5:0] p);
    logic [6:0] s;
    s = {1'b0, p} + 7'd7;
    return s[5:3];
  endfunction

  // Network mask for a prefix length
  function automatic logic [31:0] mask_for(input logic [5:0] p);
    logic [31:0] m;
    if (p == 6'd0) begin
      m = 32'h0;
    end else if (p >= MAX_PREFIX) begin
      m = 32'hFFFF_FFFF;
    end else begin
      m = 32'hFFFF_FFFF << (MAX_PREFIX - p);
    end
    return m;
  endfunction

endpackage
`default_nettype wire

FILE: design/dhcp_classless_route_parser_unit.sv
// Top level: DHCP option 121 classless route parser with stream ports.
// An accepted byte is held in the input register, then its result in the result register.
// Throughput: one byte per cycle; the input register and result register
// advance together whenever the result register is empty or being taken.
// Reset (rst_n low, synchronous): both stages empty, parser at prefix phase,
// iface_addr and iface_mask 0, broadcast_enable 1.
`default_nettype none
module dhcp_classless_route_parser_unit (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [7:0]  in_tdata,   // [7:0] data_byte
  input  wire         in_tuser,   // [0] first_byte
  input  wire         in_tlast,   // last_byte
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [79:0] out_tdata,  // [31:0] dest_addr, [37:32] prefix_length,
                                  // [69:38] gateway_addr, [75:70] route_count,
                                  // [77:76] status, [79:78] zero
  output logic [1:0]  out_tuser,  // [0] route_valid, [1] clear_routes
  output logic        out_tlast,  // option_done
  input  wire         cfg_we,
  input  wire  [1:0]  cfg_index,
  input  wire  [31:0] cfg_wdata
);

  crp_pkg::cfg_t    cfg_r;
  crp_pkg::item_t   item_r;
  crp_pkg::result_t res;
  crp_pkg::result_t res_r;
  logic             in_v_r;
  logic             out_v_r;
  logic             advance;
  logic             step;

  assign advance   = !out_v_r || out_tready;
  assign step      = advance && in_v_r;
  assign in_tready = !in_v_r || advance;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.iface_addr       <= 32'h0;
      cfg_r.iface_mask       <= 32'h0;
      cfg_r.broadcast_enable <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        crp_pkg::CFG_IFACE_ADDR: cfg_r.iface_addr       <= cfg_wdata;
        crp_pkg::CFG_IFACE_MASK: cfg_r.iface_mask       <= cfg_wdata;
        crp_pkg::CFG_BCAST_EN:   cfg_r.broadcast_enable <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r.data_byte  <= in_tdata;
      item_r.first_byte <= in_tuser;
      item_r.last_byte  <= in_tlast;
    end
  end

  crp_parser u_parser (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .item   (item_r),
    .cfg    (cfg_r),
    .result (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= in_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= res;
    end
  end

  // Pack the result transaction
  assign out_tvalid = out_v_r;
  assign out_tdata  = {2'b00, res_r.status, res_r.route_count, res_r.gateway_addr,
                       res_r.prefix_length, res_r.dest_addr};
  assign out_tuser  = {res_r.clear_routes, res_r.route_valid};
  assign out_tlast  = res_r.option_done;

endmodule
`default_nettype wire

FILE: design/crp_gw_filter.sv
// Gateway filter: flags multicast, all-ones and subnet broadcast gateways.
`default_nettype none
module crp_gw_filter (
  input  wire crp_pkg::cfg_t cfg,
  input  wire logic [31:0]   gateway,
  output logic               reject
);

  logic [31:0] host;
  logic        mcast;
  logic        all_ones;
  logic        subnet_bcast;

  // Classify the completed gateway
  always_comb begin
    host         = ~cfg.iface_mask;
    mcast        = (gateway[31:28] == 4'hE);
    all_ones     = (gateway == 32'hFFFF_FFFF);
    subnet_bcast = cfg.broadcast_enable && (gateway != cfg.iface_addr) &&
                   ((gateway & cfg.iface_mask) == (cfg.iface_addr & cfg.iface_mask)) &&
                   ((gateway & host) == host);
    reject       = mcast || all_ones || subnet_bcast;
  end

endmodule
`default_nettype wire

FILE: design/crp_parser.sv
// Byte parser: holds the entry state and computes one result per byte.
`default_nettype none
module crp_parser (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire logic            step,
  input  wire crp_pkg::item_t  item,
  input  wire crp_pkg::cfg_t   cfg,
  output crp_pkg::result_t     result
);

  logic [1:0]  phase_r, phase_nxt;
  logic [5:0]  prefix_r, prefix_nxt;
  logic [2:0]  left_r, left_nxt;
  logic [31:0] dest_r, dest_nxt;
  logic [31:0] gw_r, gw_nxt;
  logic [5:0]  count_r, count_nxt;
  logic [1:0]  err_r, err_nxt;

  logic [1:0]  phase_cur;
  logic [31:0] gw_full;
  logic [2:0]  left_dec;
  logic [2:0]  lane_diff;
  logic        reject;

  crp_gw_filter u_filter (
    .cfg     (cfg),
    .gateway (gw_full),
    .reject  (reject)
  );

  // Next state and result for the byte in hand
  always_comb begin
    gw_full   = {gw_r[23:0], item.data_byte};
    left_dec  = left_r - 3'd1;
    lane_diff = crp_pkg::octets_for(prefix_r) - left_r;

    phase_cur  = item.first_byte ? crp_pkg::PH_PREFIX : phase_r;
    count_nxt  = item.first_byte ? 6'd0 : count_r;
    err_nxt    = item.first_byte ? crp_pkg::ST_OK : err_r;
    phase_nxt  = phase_cur;
    prefix_nxt = prefix_r;
    left_nxt   = left_r;
    dest_nxt   = dest_r;
    gw_nxt     = gw_r;

    result               = '0;
    result.clear_routes  = item.first_byte;
    result.option_done   = item.last_byte;

    case (phase_cur)
      crp_pkg::PH_PREFIX: begin
        if (item.data_byte > {2'b00, crp_pkg::MAX_PREFIX}) begin
          err_nxt   = crp_pkg::ST_PREFIX;
          phase_nxt = crp_pkg::PH_STOP;
        end else begin
          prefix_nxt = item.data_byte[5:0];
          dest_nxt   = 32'h0;
          gw_nxt     = 32'h0;
          if (item.data_byte == 8'd0) begin
            left_nxt  = crp_pkg::GW_OCTETS;
            phase_nxt = crp_pkg::PH_GW;
          end else begin
            left_nxt  = crp_pkg::octets_for(item.data_byte[5:0]);
            phase_nxt = crp_pkg::PH_DEST;
          end
        end
      end
      crp_pkg::PH_DEST: begin
        // Place the octet in its lane, first octet on top
        case (lane_diff[1:0])
          2'd0:    dest_nxt[31:24] = item.data_byte;
          2'd1:    dest_nxt[23:16] = item.data_byte;
          2'd2:    dest_nxt[15:8]  = item.data_byte;
          default: dest_nxt[7:0]   = item.data_byte;
        endcase
        left_nxt = left_dec;
        if (left_dec == 3'd0) begin
          left_nxt  = crp_pkg::GW_OCTETS;
          phase_nxt = crp_pkg::PH_GW;
        end
      end
      crp_pkg::PH_GW: begin
        gw_nxt   = gw_full;
        left_nxt = left_dec;
        if (left_dec == 3'd0) begin
          phase_nxt = crp_pkg::PH_PREFIX;
          if (!reject) begin
            result.route_valid   = 1'b1;
            result.prefix_length = prefix_r;
            result.dest_addr     = dest_r & crp_pkg::mask_for(prefix_r);
            result.gateway_addr  = gw_full;
            if (count_nxt < crp_pkg::COUNT_MAX) begin
              count_nxt = count_nxt + 6'd1;
            end
          end
        end
      end
      default: begin
      end
    endcase

    // Close the option; a partial entry is a truncation
    if (item.last_byte) begin
      if (phase_nxt == crp_pkg::PH_DEST || phase_nxt == crp_pkg::PH_GW) begin
        err_nxt = crp_pkg::ST_TRUNC;
      end
      phase_nxt = crp_pkg::PH_STOP;
    end

    result.route_count = count_nxt;
    result.status      = err_nxt;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= crp_pkg::PH_PREFIX;
      count_r <= 6'd0;
      err_r   <= crp_pkg::ST_OK;
      left_r  <= 3'd0;
    end else if (step) begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
      err_r   <= err_nxt;
      left_r  <= left_nxt;
    end
  end

  // Entry accumulators
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prefix_r <= 6'd0;
      dest_r   <= 32'h0;
      gw_r     <= 32'h0;
    end else if (step) begin
      prefix_r <= prefix_nxt;
      dest_r   <= dest_nxt;
      gw_r     <= gw_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: tb/tb_dhcp_classless_route_parser_unit.sv
// Self-checking testbench for the DHCP option 121 classless route parser unit.
`timescale 1ns / 1ps
module tb_dhcp_classless_route_parser_unit;

  localparam int HOLD_OFF_CYCLES = 150;
  localparam int DRAIN_CYCLES    = 10;
  localparam int TIMEOUT_NS      = 2_000_000;
  localparam int IDLE_PERCENT    = 26;
  localparam int PHASE_ITEMS     = 8;
  localparam int SAT_ROUTES      = 65;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;   // [7:0] data_byte
  logic        in_tuser = 1'b0;    // [0] first_byte
  logic        in_tlast = 1'b0;    // last_byte
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [79:0] out_tdata;          // [31:0] dest_addr, [37:32] prefix_length,
                                   // [69:38] gateway_addr, [75:70] route_count,
                                   // [77:76] status, [79:78] zero
  logic [1:0]  out_tuser;          // [0] route_valid, [1] clear_routes
  logic        out_tlast;          // option_done
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = crp_pkg::CFG_IFACE_ADDR;
  logic [31:0] cfg_wdata = 32'h0;

  dhcp_classless_route_parser_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // Mirror of the parser state and interface settings
  crp_pkg::cfg_t cur_cfg = '{iface_addr: 32'h0, iface_mask: 32'h0,
                             broadcast_enable: 1'b1};
  logic [1:0]  parse_phase = crp_pkg::PH_PREFIX;
  logic [5:0]  route_pfx = 6'd0;
  logic [2:0]  octets_todo = 3'd0;
  logic [31:0] dest_acc = 32'h0;
  logic [31:0] gw_acc = 32'h0;
  logic [5:0]  routes_taken = 6'd0;
  logic [1:0]  parse_status = crp_pkg::ST_OK;

  crp_pkg::result_t expected_routes[$];
  int          mismatches = 0;
  logic        steady = 1'b0;
  logic        hold_off_req = 1'b0;

  // Free-running clock
  initial begin
    forever #5 clk = ~clk;
  end

  // Abort a hung run
  initial begin
    #(TIMEOUT_NS);
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic logic [31:0] prefix_mask(input logic [5:0] len);
    return ~(32'hFFFF_FFFF >> len);
  endfunction

  function automatic logic [2:0] dest_octets(input logic [5:0] len);
    int n;
    n = (int'(len) + 7) / 8;
    return n[2:0];
  endfunction

  // Multicast, limited broadcast and directed subnet broadcast are refused
  function automatic logic gw_refused(input logic [31:0] g);
    logic [31:0] host;
    host = ~cur_cfg.iface_mask;
    if (g[31:28] == 4'hE) return 1'b1;
    if (g == 32'hFFFF_FFFF) return 1'b1;
    if (!cur_cfg.broadcast_enable) return 1'b0;
    if (g == cur_cfg.iface_addr) return 1'b0;
    return ((g & cur_cfg.iface_mask) == (cur_cfg.iface_addr & cur_cfg.iface_mask)) &&
           ((g & host) == host);
  endfunction

  // Advance the parser mirror by one byte and build the expected result
  task automatic parse_byte(input crp_pkg::item_t it, output crp_pkg::result_t r);
    logic [1:0] idx;
    r = '0;
    if (it.first_byte) begin
      parse_phase  = crp_pkg::PH_PREFIX;
      routes_taken = 6'd0;
      parse_status = crp_pkg::ST_OK;
    end
    case (parse_phase)
      crp_pkg::PH_PREFIX: begin
        if (it.data_byte > crp_pkg::MAX_PREFIX) begin
          parse_status = crp_pkg::ST_PREFIX;
          parse_phase  = crp_pkg::PH_STOP;
        end else begin
          route_pfx   = it.data_byte[5:0];
          dest_acc    = 32'h0;
          gw_acc      = 32'h0;
          octets_todo = dest_octets(route_pfx);
          if (octets_todo == 3'd0) begin
            octets_todo = crp_pkg::GW_OCTETS;
            parse_phase = crp_pkg::PH_GW;
          end else begin
            parse_phase = crp_pkg::PH_DEST;
          end
        end
      end
      crp_pkg::PH_DEST: begin
        idx = 2'(dest_octets(route_pfx) - octets_todo);
        dest_acc = dest_acc | ({24'h0, it.data_byte} << (24 - 8 * int'(idx)));
        octets_todo = octets_todo - 3'd1;
        if (octets_todo == 3'd0) begin
          octets_todo = crp_pkg::GW_OCTETS;
          parse_phase = crp_pkg::PH_GW;
        end
      end
      crp_pkg::PH_GW: begin
        gw_acc = {gw_acc[23:0], it.data_byte};
        octets_todo = octets_todo - 3'd1;
        if (octets_todo == 3'd0) begin
          parse_phase = crp_pkg::PH_PREFIX;
          if (!gw_refused(gw_acc)) begin
            r.route_valid   = 1'b1;
            r.prefix_length = route_pfx;
            r.dest_addr     = dest_acc & prefix_mask(route_pfx);
            r.gateway_addr  = gw_acc;
            if (routes_taken < crp_pkg::COUNT_MAX) routes_taken = routes_taken + 6'd1;
          end
        end
      end
      default: begin
      end
    endcase
    if (it.last_byte) begin
      if (parse_phase == crp_pkg::PH_DEST || parse_phase == crp_pkg::PH_GW) begin
        parse_status = crp_pkg::ST_TRUNC;
      end
      parse_phase = crp_pkg::PH_STOP;
    end
    r.clear_routes = it.first_byte;
    r.option_done  = it.last_byte;
    r.route_count  = routes_taken;
    r.status       = parse_status;
  endtask

  // Offer one byte, wait for its transaction, record the expected result
  task automatic send_byte(input logic [7:0] b, input logic first, input logic last);
    crp_pkg::item_t   it;
    crp_pkg::result_t r;
    it = '{data_byte: b, first_byte: first, last_byte: last};
    if (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= first;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    parse_byte(it, r);
    expected_routes.push_back(r);
  endtask

  // Stop offering and wait until every expected result has been taken
  task automatic wait_results_drained();
    in_tvalid <= 1'b0;
    while (expected_routes.size() != 0) @(posedge clk);
  endtask

  // Write all three interface registers back to back
  task automatic apply_iface_setting(input logic [31:0] addr, input logic [31:0] mask,
                                     input logic bcast);
    cfg_we    <= 1'b1;
    cfg_index <= crp_pkg::CFG_IFACE_ADDR;
    cfg_wdata <= addr;
    @(posedge clk);
    cfg_index <= crp_pkg::CFG_IFACE_MASK;
    cfg_wdata <= mask;
    @(posedge clk);
    cfg_index <= crp_pkg::CFG_BCAST_EN;
    cfg_wdata <= {31'h0, bcast};
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_cfg = '{iface_addr: addr, iface_mask: mask, broadcast_enable: bcast};
  endtask

  // Bias gateways toward the refusal boundaries of the current setting
  function automatic logic [31:0] pick_gateway();
    logic [31:0] g;
    case ($urandom_range(0, 9))
      0: g = 32'h0;
      1: g = 32'hFFFF_FFFF;
      2: g = ($urandom & 32'h0FFF_FFFF) | 32'hE000_0000;
      3: g = cur_cfg.iface_addr | ~cur_cfg.iface_mask;
      4: g = cur_cfg.iface_addr;
      5: g = (cur_cfg.iface_addr & cur_cfg.iface_mask) | ($urandom & ~cur_cfg.iface_mask);
      default: g = $urandom;
    endcase
    return g;
  endfunction

  function automatic crp_pkg::item_t plain_item(input logic [7:0] b);
    return '{data_byte: b, first_byte: 1'b0, last_byte: 1'b0};
  endfunction

  // Build one option body, optionally broken, and send it; return its length
  task automatic send_option(input int routes, output int sent);
    crp_pkg::item_t seq[$];
    logic [7:0]  pfx;
    logic [31:0] gw;
    int          kind;
    int          cut;
    kind = $urandom_range(0, 99);
    if (kind >= 36 && kind < 40) begin
      // single-byte option carrying both marks
      seq.push_back('{data_byte: 8'($urandom_range(0, 255)), first_byte: 1'b1,
                      last_byte: 1'b1});
    end else begin
      for (int r = 0; r < routes; r++) begin
        case ($urandom_range(0, 9))
          0: pfx = 8'd0;
          1: pfx = 8'd32;
          default: pfx = 8'($urandom_range(0, 32));
        endcase
        if (kind < 8 && r == routes - 1) begin
          // bad prefix length, then bytes the parser must ignore
          seq.push_back(plain_item(8'($urandom_range(33, 255))));
          seq.push_back(plain_item(8'($urandom_range(0, 255))));
          seq.push_back(plain_item(8'($urandom_range(0, 255))));
          break;
        end
        seq.push_back(plain_item(pfx));
        for (int i = 0; i < (int'(pfx) + 7) / 8; i++)
          seq.push_back(plain_item(8'($urandom_range(0, 255))));
        gw = pick_gateway();
        for (int i = 3; i >= 0; i--) seq.push_back(plain_item(gw[8 * i +: 8]));
      end
      seq[0].first_byte = 1'b1;
      // truncate the tail so the last mark lands inside an entry
      if (kind >= 8 && kind < 18 && seq.size() > 1) begin
        cut = $urandom_range(1, (seq.size() > 8) ? 8 : seq.size() - 1);
        repeat (cut) void'(seq.pop_back());
      end
      // restart the option from the middle
      if (kind >= 18 && kind < 25 && seq.size() > 1)
        seq[$urandom_range(1, seq.size() - 1)].first_byte = 1'b1;
      // mark the last byte, except leave the option open for the next one to cut off
      if (kind < 25 || kind >= 30) seq[seq.size() - 1].last_byte = 1'b1;
      // trailing noise after the last mark
      if (kind >= 30 && kind < 36) begin
        repeat ($urandom_range(1, 3))
          seq.push_back('{data_byte: 8'($urandom_range(0, 255)), first_byte: 1'b0,
                          last_byte: 1'($urandom_range(0, 1))});
      end
    end
    foreach (seq[i]) send_byte(seq[i].data_byte, seq[i].first_byte, seq[i].last_byte);
    sent = seq.size();
  endtask

  // Receiver: random back-pressure, with an on-demand long hold-off
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      out_tready <= steady ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PERCENT);
    end
  end

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  // Compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    crp_pkg::result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_routes.size() == 0) begin
        $error("result transaction with no expected result: tdata 0x%0h", out_tdata);
        mismatches++;
      end else begin
        exp_r = expected_routes.pop_front();
        check_field("route_valid", 32'(exp_r.route_valid), 32'(out_tuser[0]));
        check_field("dest_addr", exp_r.dest_addr, out_tdata[31:0]);
        check_field("prefix_length", 32'(exp_r.prefix_length), 32'(out_tdata[37:32]));
        check_field("gateway_addr", exp_r.gateway_addr, out_tdata[69:38]);
        check_field("clear_routes", 32'(exp_r.clear_routes), 32'(out_tuser[1]));
        check_field("option_done", 32'(exp_r.option_done), 32'(out_tlast));
        check_field("route_count", 32'(exp_r.route_count), 32'(out_tdata[75:70]));
        check_field("status", 32'(exp_r.status), 32'(out_tdata[77:76]));
      end
    end
  end

  // Bytes before any first mark, ending in an on-link route via 0.0.0.0
  task automatic test_reset_start();
    apply_iface_setting(32'h0A00_00FF, 32'hFFFF_FF00, 1'b1);
    send_byte(8'd0, 1'b0, 1'b0);
    repeat (4) send_byte(8'h00, 1'b0, 1'b0);
  endtask

  // First mark inside an entry, then a /32 route whose gateway is the interface
  task automatic test_mark_handling();
    send_byte(8'd9, 1'b1, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'd32, 1'b1, 1'b0);
    repeat (4) send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'h0A, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);
  endtask

  // Prefix above 32 with the last mark, an ignored byte, then a truncated entry
  task automatic test_error_paths();
    send_byte(8'hFF, 1'b0, 1'b1);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'd9, 1'b1, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'h01, 1'b0, 1'b1);
  endtask

  // Enough default routes in one option to saturate the route counter
  task automatic test_count_saturation();
    logic [31:0] gw;
    steady = 1'b1;
    send_byte(8'd0, 1'b1, 1'b0);
    for (int r = 0; r < SAT_ROUTES; r++) begin
      if (r != 0) send_byte(8'd0, 1'b0, 1'b0);
      gw = {8'($urandom_range(1, 8'hDF)), 24'($urandom)};
      for (int i = 3; i >= 0; i--) send_byte(gw[8 * i +: 8], 1'b0, r == SAT_ROUTES - 1 && i == 0);
    end
    steady = 1'b0;
  endtask

  // Random options across several interface settings
  task automatic test_random_settings();
    logic [31:0] addr;
    int          count;
    int          sent;
    for (int s = 0; s < 6; s++) begin
      wait_results_drained();
      addr = $urandom;
      case (s)
        0: apply_iface_setting(32'h0, 32'h0, 1'b0);
        1: apply_iface_setting(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        2: apply_iface_setting(addr, prefix_mask(6'($urandom_range(8, 30))), 1'b1);
        3: apply_iface_setting(addr, prefix_mask(6'($urandom_range(8, 30))), 1'b0);
        4: apply_iface_setting(addr, 32'h0, 1'b1);
        default: apply_iface_setting(addr, prefix_mask(6'($urandom_range(0, 32))), 1'b1);
      endcase
      steady = (s == 5);
      if (s == 2) hold_off_req = 1'b1;
      count = 0;
      while (count < PHASE_ITEMS) begin
        send_option($urandom_range(1, 4), sent);
        count += sent;
      end
      steady = 1'b0;
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_start();
    test_mark_handling();
    test_error_paths();
    test_count_saturation();
    test_random_settings();
    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_routes.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
